// ===== hw/rtl/stt_pkg.sv =====
package stt_pkg;

    // Width of the running byte offset and the open token's start.
    localparam int OFFSET_BITS = 16;

    localparam int KIND_W  = 5;
    localparam int FIELD_W = 16;
    localparam int COUNT_W = FIELD_W + 1;

    // Output queue depth and pointer width.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [FIELD_W-1:0] LEN_MAX = {FIELD_W{1'b1}};

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_SEMI      = 5'd0;
    localparam logic [KIND_W-1:0] KIND_COLON     = 5'd1;
    localparam logic [KIND_W-1:0] KIND_COMMA     = 5'd2;
    localparam logic [KIND_W-1:0] KIND_LPAREN    = 5'd3;
    localparam logic [KIND_W-1:0] KIND_RPAREN    = 5'd4;
    localparam logic [KIND_W-1:0] KIND_LBRACE    = 5'd5;
    localparam logic [KIND_W-1:0] KIND_RBRACE    = 5'd6;
    localparam logic [KIND_W-1:0] KIND_LBRACKET  = 5'd7;
    localparam logic [KIND_W-1:0] KIND_RBRACKET  = 5'd8;
    localparam logic [KIND_W-1:0] KIND_ASSIGN    = 5'd9;
    localparam logic [KIND_W-1:0] KIND_EQUAL     = 5'd10;
    localparam logic [KIND_W-1:0] KIND_BANG      = 5'd11;
    localparam logic [KIND_W-1:0] KIND_NOT_EQUAL = 5'd12;
    localparam logic [KIND_W-1:0] KIND_PLUS      = 5'd13;
    localparam logic [KIND_W-1:0] KIND_MINUS     = 5'd14;
    localparam logic [KIND_W-1:0] KIND_STAR      = 5'd15;
    localparam logic [KIND_W-1:0] KIND_SLASH     = 5'd16;
    localparam logic [KIND_W-1:0] KIND_LESS      = 5'd17;
    localparam logic [KIND_W-1:0] KIND_GREATER   = 5'd18;
    localparam logic [KIND_W-1:0] KIND_STRING    = 5'd19;
    localparam logic [KIND_W-1:0] KIND_IDENT     = 5'd20;
    localparam logic [KIND_W-1:0] KIND_INTEGER   = 5'd21;
    localparam logic [KIND_W-1:0] KIND_ILLEGAL   = 5'd22;
    localparam logic [KIND_W-1:0] KIND_EOF       = 5'd23;

    // Characters with special meaning
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SEMI  = 8'h3b;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_EQ,
        MODE_BANG,
        MODE_IDENT,
        MODE_NUM,
        MODE_STR_SQ,
        MODE_STR_DQ
    } mode_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
        logic               last;
    } token_t;

    // Up to two tokens written into the queue in one cycle, first in slot a.
    typedef struct packed {
        logic [1:0] count;
        token_t     a;
        token_t     b;
    } push_t;

endpackage

// ===== hw/rtl/source_text_tokenizer_core.sv =====
// Channel  | Handshake              | Payload
// ---------+------------------------+---------------------------------------------
// input    | in_valid / in_ready    | in_byte
// output   | out_valid / out_ready  | token_kind, token_start, token_length,
//          |                        | last_of_run
//
// One byte request is taken per cycle while the queue has room for two tokens.
// In the input register the scanner updates the mode, start and length registers and
// writes zero, one or two tokens into a four-entry output queue; the first
// token can leave on the following cycle. Sustained rate is one byte per cycle
// while bytes yield at most one token each and the output does not stall; a
// byte that yields two tokens adds a second token to drain, and the queue depth
// sets how many such bytes are absorbed before in_ready drops.
// Reset clears the mode to idle, the byte offset to zero and empties the queue.
// A stalled output holds the queue; the input register holds its byte until
// the queue has room for two tokens.
module source_text_tokenizer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    in_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [stt_pkg::KIND_W-1:0]    token_kind,
    output logic [stt_pkg::FIELD_W-1:0]   token_start,
    output logic [stt_pkg::FIELD_W-1:0]   token_length,
    output logic                          last_of_run
);

    logic                        byte_vld_reg;
    logic [7:0]                  byte_reg;
    logic                        fire;
    logic                        room_two;
    logic [stt_pkg::QCNT_W-1:0]  fill;
    stt_pkg::push_t              push;
    stt_pkg::token_t             head;

    // Advance the held byte once the queue can take both possible tokens.
    assign fire     = byte_vld_reg && room_two;
    assign in_ready = !byte_vld_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_vld_reg <= 1'b0;
        else if (in_ready)
            byte_vld_reg <= in_valid;
    end

    // Payload register: load on every accepted request.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= in_byte;
    end

    stt_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .in_byte (byte_reg),
        .push    (push)
    );

    stt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (out_ready),
        .room_two  (room_two),
        .not_empty (out_valid),
        .fill      (fill),
        .head      (head)
    );

    assign token_kind   = head.kind;
    assign token_start  = head.start;
    assign token_length = head.length;
    assign last_of_run  = head.last;

`ifndef NO_ASSERTIONS
    // A scan step never writes more tokens than the queue has free.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill + stt_pkg::QCNT_W'(push.count) <= stt_pkg::QCNT_W'(stt_pkg::QDEPTH))
        else $error("token queue overflow");

    // Tokens are written only while a byte advances.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> fire)
        else $error("token written without an advancing byte");

    // Of two tokens from one byte, only the second closes the run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (!push.a.last && push.b.last))
        else $error("last_of_run misplaced on a two-token byte");

    // The queue fill tracks writes and reads.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> fill == $past(fill) + stt_pkg::QCNT_W'($past(push.count))
                 - stt_pkg::QCNT_W'($past(out_ready && out_valid)))
        else $error("token queue fill mismatch");
`endif

endmodule

// ===== hw/rtl/stt_scan.sv =====
module stt_scan (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [7:0]           in_byte,
    output stt_pkg::push_t       push
);

    stt_pkg::mode_t                    mode_reg, mode_next;
    logic [stt_pkg::OFFSET_BITS-1:0]   begin_reg, begin_next;
    logic [stt_pkg::OFFSET_BITS-1:0]   offset_reg, offset_next;
    logic [stt_pkg::COUNT_W-1:0]       count_reg, count_next;

    stt_pkg::token_t                   close_tok, start_tok;
    logic                              close_vld, start_vld, run_start;
    logic [7:0]                        b;
    logic                              is_space, is_numeral, is_letter;
    logic                              single_vld;
    logic [stt_pkg::KIND_W-1:0]        single_kind;
    logic [31:0]                       begin_wide, offset_wide, offset_p1_wide;
    logic [stt_pkg::FIELD_W-1:0]       open_len;
    logic                              is_quote;

    assign b          = in_byte;
    assign is_space   = b inside {[8'd9:8'd13], 8'd32};
    assign is_numeral = b inside {[8'h30:8'h39]};
    assign is_letter  = b inside {[8'h61:8'h7a], [8'h41:8'h5a], stt_pkg::CH_UNDER};

    assign begin_wide     = 32'(begin_reg);
    assign offset_wide    = 32'(offset_reg);
    assign offset_p1_wide = 32'(offset_reg + 1'b1);
    assign open_len       = count_reg[stt_pkg::FIELD_W] ? stt_pkg::LEN_MAX
                                                        : count_reg[stt_pkg::FIELD_W-1:0];
    assign is_quote       = (mode_reg == stt_pkg::MODE_STR_SQ) ? (b == stt_pkg::CH_SQ)
                                                               : (b == stt_pkg::CH_DQ);

    always_comb
    begin
        single_vld  = 1'b1;
        single_kind = stt_pkg::KIND_ILLEGAL;
        case (b)
            stt_pkg::CH_SEMI: single_kind = stt_pkg::KIND_SEMI;
            8'h3a:            single_kind = stt_pkg::KIND_COLON;
            8'h2c:            single_kind = stt_pkg::KIND_COMMA;
            8'h28:            single_kind = stt_pkg::KIND_LPAREN;
            8'h29:            single_kind = stt_pkg::KIND_RPAREN;
            8'h7b:            single_kind = stt_pkg::KIND_LBRACE;
            8'h7d:            single_kind = stt_pkg::KIND_RBRACE;
            8'h5b:            single_kind = stt_pkg::KIND_LBRACKET;
            8'h5d:            single_kind = stt_pkg::KIND_RBRACKET;
            8'h2b:            single_kind = stt_pkg::KIND_PLUS;
            8'h2d:            single_kind = stt_pkg::KIND_MINUS;
            8'h2a:            single_kind = stt_pkg::KIND_STAR;
            8'h2f:            single_kind = stt_pkg::KIND_SLASH;
            8'h3c:            single_kind = stt_pkg::KIND_LESS;
            8'h3e:            single_kind = stt_pkg::KIND_GREATER;
            default:          single_vld  = 1'b0;
        endcase
    end

    always_comb
    begin
        mode_next   = mode_reg;
        begin_next  = begin_reg;
        count_next  = count_reg;
        offset_next = offset_reg + 1'b1;
        close_vld   = 1'b0;
        run_start   = 1'b0;
        close_tok   = '0;
        start_vld   = 1'b0;
        start_tok   = '0;

        // Close or extend the open token.
        case (mode_reg)
            stt_pkg::MODE_EQ, stt_pkg::MODE_BANG:
            begin
                close_vld       = 1'b1;
                close_tok.start = begin_wide[stt_pkg::FIELD_W-1:0];
                if (b == stt_pkg::CH_EQ) begin
                    close_tok.kind   = (mode_reg == stt_pkg::MODE_EQ) ? stt_pkg::KIND_EQUAL
                                                                      : stt_pkg::KIND_NOT_EQUAL;
                    close_tok.length = stt_pkg::FIELD_W'(2);
                    mode_next        = stt_pkg::MODE_IDLE;
                end else begin
                    close_tok.kind   = (mode_reg == stt_pkg::MODE_EQ) ? stt_pkg::KIND_ASSIGN
                                                                      : stt_pkg::KIND_BANG;
                    close_tok.length = stt_pkg::FIELD_W'(1);
                    run_start        = 1'b1;
                end
            end
            stt_pkg::MODE_IDENT, stt_pkg::MODE_NUM:
            begin
                if (is_numeral || (is_letter && mode_reg == stt_pkg::MODE_IDENT)) begin
                    if (!count_reg[stt_pkg::FIELD_W])
                        count_next = count_reg + 1'b1;
                end else begin
                    close_vld        = 1'b1;
                    close_tok.kind   = (mode_reg == stt_pkg::MODE_IDENT) ? stt_pkg::KIND_IDENT
                                                                         : stt_pkg::KIND_INTEGER;
                    close_tok.start  = begin_wide[stt_pkg::FIELD_W-1:0];
                    close_tok.length = open_len;
                    run_start        = 1'b1;
                end
            end
            stt_pkg::MODE_STR_SQ, stt_pkg::MODE_STR_DQ:
            begin
                if (is_quote || b == stt_pkg::CH_NUL) begin
                    close_vld        = 1'b1;
                    close_tok.kind   = stt_pkg::KIND_STRING;
                    close_tok.start  = begin_wide[stt_pkg::FIELD_W-1:0];
                    close_tok.length = open_len;
                    if (is_quote)
                        mode_next = stt_pkg::MODE_IDLE;
                    else
                        run_start = 1'b1;
                end else if (!count_reg[stt_pkg::FIELD_W]) begin
                    count_next = count_reg + 1'b1;
                end
            end
            default:
                run_start = 1'b1;
        endcase

        // Handle the byte as the first byte of a new token.
        if (run_start) begin
            mode_next       = stt_pkg::MODE_IDLE;
            start_tok.start = offset_wide[stt_pkg::FIELD_W-1:0];
            if (b == stt_pkg::CH_NUL) begin
                start_vld        = 1'b1;
                start_tok.kind   = stt_pkg::KIND_EOF;
                start_tok.length = '0;
                offset_next      = '0;
                begin_next       = '0;
                count_next       = '0;
            end else if (is_space) begin
                start_vld = 1'b0;
            end else if (single_vld) begin
                start_vld        = 1'b1;
                start_tok.kind   = single_kind;
                start_tok.length = stt_pkg::FIELD_W'(1);
            end else if (b == stt_pkg::CH_EQ || b == stt_pkg::CH_BANG || is_letter
                         || is_numeral) begin
                begin_next = offset_reg;
                count_next = stt_pkg::COUNT_W'(1);
                if (b == stt_pkg::CH_EQ)
                    mode_next = stt_pkg::MODE_EQ;
                else if (b == stt_pkg::CH_BANG)
                    mode_next = stt_pkg::MODE_BANG;
                else if (is_letter)
                    mode_next = stt_pkg::MODE_IDENT;
                else
                    mode_next = stt_pkg::MODE_NUM;
            end else if (b == stt_pkg::CH_SQ || b == stt_pkg::CH_DQ) begin
                begin_next = offset_p1_wide[stt_pkg::OFFSET_BITS-1:0];
                count_next = '0;
                mode_next  = (b == stt_pkg::CH_SQ) ? stt_pkg::MODE_STR_SQ
                                                   : stt_pkg::MODE_STR_DQ;
            end else begin
                start_vld        = 1'b1;
                start_tok.kind   = stt_pkg::KIND_ILLEGAL;
                start_tok.length = stt_pkg::FIELD_W'(1);
            end
        end
    end

    // Pack results so slot a always holds the first one.
    always_comb
    begin
        push = '0;
        if (close_vld) begin
            push.a      = close_tok;
            push.a.last = !start_vld;
            push.b      = start_tok;
            push.b.last = 1'b1;
        end else begin
            push.a      = start_tok;
            push.a.last = 1'b1;
        end
        if (fire)
            push.count = {1'b0, close_vld} + {1'b0, start_vld};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= stt_pkg::MODE_IDLE;
            begin_reg  <= '0;
            offset_reg <= '0;
            count_reg  <= '0;
        end else if (fire) begin
            mode_reg   <= mode_next;
            begin_reg  <= begin_next;
            offset_reg <= offset_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/stt_queue.sv =====
module stt_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  stt_pkg::push_t               push,
    input  logic                         pop,
    output logic                         room_two,
    output logic                         not_empty,
    output logic [stt_pkg::QCNT_W-1:0]   fill,
    output stt_pkg::token_t              head
);

    stt_pkg::token_t                 entry_reg [stt_pkg::QDEPTH];
    logic [stt_pkg::QPTR_W-1:0]      wr_reg, wr_next, rd_reg, rd_next, wr_p1;
    logic [stt_pkg::QCNT_W-1:0]      cnt_reg, cnt_next;
    logic                            do_pop;

    assign do_pop    = pop && (cnt_reg != '0);
    assign wr_p1     = wr_reg + 1'b1;
    assign not_empty = (cnt_reg != '0);
    assign head      = entry_reg[rd_reg];
    assign fill      = cnt_reg;
    assign room_two  = (cnt_reg <= stt_pkg::QCNT_W'(stt_pkg::QDEPTH - 2));

    always_comb
    begin
        wr_next  = wr_reg + stt_pkg::QPTR_W'(push.count);
        rd_next  = rd_reg + stt_pkg::QPTR_W'(do_pop);
        cnt_next = cnt_reg + stt_pkg::QCNT_W'(push.count) - stt_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_reg] <= push.a;
        if (push.count == 2'd2)
            entry_reg[wr_p1] <= push.b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== sim/source_text_tokenizer_core_tb.sv =====
module source_text_tokenizer_core_tb;
    import stt_pkg::*;

    // Random texts stop once about this many byte requests have gone in.
    localparam int TEXT_ITEMS    = 1050;
    // Longest gap either side inserts before a request.
    localparam int MAX_IDLE      = 14;
    // Quiet cycles after the last token before the next phase or the end.
    localparam int SETTLE_CYCLES = 16;
    // Length of the long identifier sent without pauses.
    localparam int LONG_IDENT    = 60;

    localparam logic [7:0] CH_SPACE = 8'h20;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [7:0]          in_byte;
    logic                out_valid;
    logic                out_ready;
    logic [KIND_W-1:0]   token_kind;
    logic [FIELD_W-1:0]  token_start;
    logic [FIELD_W-1:0]  token_length;
    logic                last_of_run;

    // Pacing switches: when clear, that side never idles.
    bit tx_pace = 1'b1;
    bit rx_pace = 1'b1;
    int mismatches = 0;

    // Tokens predicted but not yet seen on the output, oldest first.
    token_t token_q[$];

    // Scanner state as the testbench tracks it.
    mode_t                  scan_state;
    logic [OFFSET_BITS-1:0] tok_begin;
    logic [OFFSET_BITS-1:0] next_offset;
    logic [COUNT_W-1:0]     tok_len;

    // Character sets the random texts draw from.
    string punct_set = ";:,(){}[]+-*/<>";
    string word_set  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string digit_set = "0123456789";
    string stray_set = "#$%&.?@\\^|~";

    source_text_tokenizer_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .last_of_run  (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case a request or a token never gets through.
    initial
    begin
        #100_000_000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Byte classes
    // ------------------------------------------------------------------

    function automatic bit is_blank(logic [7:0] b);
        return b == CH_SPACE || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic bit is_numeral(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_word(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_UNDER;
    endfunction

    // Map a one-byte punctuation or operator to its kind; return 0 if it is none.
    function automatic bit punct_kind(input logic [7:0] b, output logic [KIND_W-1:0] k);
        k = KIND_SEMI;
        case (b)
            CH_SEMI: k = KIND_SEMI;
            ":":     k = KIND_COLON;
            ",":     k = KIND_COMMA;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            "[":     k = KIND_LBRACKET;
            "]":     k = KIND_RBRACKET;
            "+":     k = KIND_PLUS;
            "-":     k = KIND_MINUS;
            "*":     k = KIND_STAR;
            "/":     k = KIND_SLASH;
            "<":     k = KIND_LESS;
            ">":     k = KIND_GREATER;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Token predictor
    // ------------------------------------------------------------------

    // Queue one expected token; the length field saturates, the start keeps
    // its low bits.
    function automatic void expect_token(logic [KIND_W-1:0] kind,
                                         logic [OFFSET_BITS-1:0] start,
                                         logic [COUNT_W-1:0] len);
        token_t t;
        t.kind   = kind;
        t.start  = FIELD_W'(start);
        t.length = (len > LEN_MAX) ? LEN_MAX : len[FIELD_W-1:0];
        t.last   = 1'b0;
        token_q.push_back(t);
    endfunction

    function automatic void open_token(mode_t mode, logic [OFFSET_BITS-1:0] start,
                                       logic [COUNT_W-1:0] len);
        scan_state = mode;
        tok_begin  = start;
        tok_len    = len;
    endfunction

    // Stop counting one past the field maximum so the report saturates.
    function automatic void extend_token();
        if (tok_len <= LEN_MAX)
            tok_len++;
    endfunction

    // A byte seen between tokens: skip it, emit it, or open a new token.
    function automatic void begin_token(logic [7:0] b, logic [OFFSET_BITS-1:0] pos);
        logic [KIND_W-1:0] k;
        scan_state = MODE_IDLE;
        if (b == CH_NUL)
        begin
            // End of text: eof at the terminator's offset, then start over.
            expect_token(KIND_EOF, pos, '0);
            next_offset = '0;
            tok_begin   = '0;
            tok_len     = '0;
        end
        else if (punct_kind(b, k))
            expect_token(k, pos, 1);
        else if (b == CH_EQ)
            open_token(MODE_EQ, pos, 1);
        else if (b == CH_BANG)
            open_token(MODE_BANG, pos, 1);
        else if (b == CH_SQ)
            open_token(MODE_STR_SQ, pos + 1'b1, 0);
        else if (b == CH_DQ)
            open_token(MODE_STR_DQ, pos + 1'b1, 0);
        else if (is_word(b))
            open_token(MODE_IDENT, pos, 1);
        else if (is_numeral(b))
            open_token(MODE_NUM, pos, 1);
        else if (!is_blank(b))
            expect_token(KIND_ILLEGAL, pos, 1);
    endfunction

    // Advance the scanner by one accepted byte and queue what it yields.
    function automatic void predict_byte(logic [7:0] b);
        logic [OFFSET_BITS-1:0] pos;
        int                     queued;
        queued      = token_q.size();
        pos         = next_offset;
        next_offset = pos + 1'b1;
        case (scan_state)
            MODE_EQ, MODE_BANG:
            begin
                if (b == CH_EQ)
                begin
                    expect_token(scan_state == MODE_EQ ? KIND_EQUAL : KIND_NOT_EQUAL,
                                 tok_begin, 2);
                    scan_state = MODE_IDLE;
                end
                else
                begin
                    // Lone operator; the lookahead byte starts the next token.
                    expect_token(scan_state == MODE_EQ ? KIND_ASSIGN : KIND_BANG,
                                 tok_begin, 1);
                    begin_token(b, pos);
                end
            end
            MODE_IDENT:
            begin
                if (is_word(b) || is_numeral(b))
                    extend_token();
                else
                begin
                    expect_token(KIND_IDENT, tok_begin, tok_len);
                    begin_token(b, pos);
                end
            end
            MODE_NUM:
            begin
                if (is_numeral(b))
                    extend_token();
                else
                begin
                    expect_token(KIND_INTEGER, tok_begin, tok_len);
                    begin_token(b, pos);
                end
            end
            MODE_STR_SQ, MODE_STR_DQ:
            begin
                if (b == (scan_state == MODE_STR_SQ ? CH_SQ : CH_DQ))
                begin
                    expect_token(KIND_STRING, tok_begin, tok_len);
                    scan_state = MODE_IDLE;
                end
                else if (b == CH_NUL)
                begin
                    // Unterminated string runs to the end of text, eof follows.
                    expect_token(KIND_STRING, tok_begin, tok_len);
                    begin_token(b, pos);
                end
                else
                    extend_token();
            end
            default:
                begin_token(b, pos);
        endcase
        if (token_q.size() > queued)
            token_q[token_q.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Send one byte request. Valid stays high after acceptance so that a
    // back-to-back request never lowers and raises it in the same step; the
    // next call drops it only if it draws a gap, and settle() drops it.
    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = tx_pace ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_byte(b);
    endtask

    task automatic send_string(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Drop valid, wait until every predicted token has come out, then hold
    // off a little longer to catch stray tokens.
    task automatic settle();
        in_valid <= 1'b0;
        while (token_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Draw a stall for every token, then hold ready until it is taken.
    initial
    begin : token_sink
        int gap;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = rx_pace ? $urandom_range(0, MAX_IDLE) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    function automatic void check_field(string name, logic [FIELD_W-1:0] want,
                                        logic [FIELD_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Compare every accepted token with the oldest prediction.
    always @(posedge clk)
    begin : token_check
        token_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (token_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: token with none predicted: kind %0d start %0d length %0d",
                         $time, token_kind, token_start, token_length);
            end
            else
            begin
                want = token_q.pop_front();
                check_field("token_kind", FIELD_W'(want.kind), FIELD_W'(token_kind));
                check_field("token_start", want.start, token_start);
                check_field("token_length", want.length, token_length);
                check_field("last_of_run", FIELD_W'(want.last), FIELD_W'(last_of_run));
            end
        end
    end

    // ------------------------------------------------------------------
    // Random text builder
    // ------------------------------------------------------------------

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic logic [7:0] blank_byte();
        return ($urandom_range(0, 5) == 0) ? CH_SPACE : 8'($urandom_range(9, 13));
    endfunction

    // Any string body byte except the closing quote and the terminator.
    function automatic logic [7:0] string_byte(logic [7:0] quote);
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == quote);
        return b;
    endfunction

    // Mostly well-formed tokens, packed tight or separated, with some noise.
    function automatic void compose_text(ref logic [7:0] text[$]);
        logic [7:0] quote;
        text.delete();
        repeat ($urandom_range(0, 12))
        begin
            case ($urandom_range(0, 9))
                0: text.push_back(pick(punct_set));
                1:
                begin
                    text.push_back($urandom_range(0, 1) ? CH_EQ : CH_BANG);
                    if ($urandom_range(0, 1))
                        text.push_back(CH_EQ);
                end
                2, 3:
                begin
                    text.push_back(pick(word_set));
                    repeat ($urandom_range(0, 7))
                        text.push_back($urandom_range(0, 3) == 0 ? pick(digit_set)
                                                                 : pick(word_set));
                end
                4:
                    repeat ($urandom_range(1, 6))
                        text.push_back(pick(digit_set));
                5, 6:
                begin
                    quote = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
                    text.push_back(quote);
                    repeat ($urandom_range(0, 6))
                        text.push_back(string_byte(quote));
                    text.push_back(quote);
                end
                7: text.push_back($urandom_range(0, 1) ? pick(stray_set)
                                                       : 8'($urandom_range(128, 255)));
                8: text.push_back(8'($urandom_range(1, 255)));
                default:
                    repeat ($urandom_range(1, 3))
                        text.push_back(blank_byte());
            endcase
            if ($urandom_range(0, 1))
                text.push_back(blank_byte());
        end
        // Now and then leave a string open so the terminator has to close it.
        if ($urandom_range(0, 7) == 0)
        begin
            quote = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
            text.push_back(quote);
            repeat ($urandom_range(0, 5))
                text.push_back(string_byte(quote));
        end
        text.push_back(CH_NUL);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every one-byte punctuation and operator, back to back, then eof.
    task automatic test_punctuation();
        send_string(";:,(){}[]+-*/<>");
        send_byte(CH_NUL);
        settle();
    endtask

    // Identifiers, integers, == and !=, lone = and ! closed by the next token,
    // high bytes, an empty string, an unterminated string and a lone = at
    // end of text.
    task automatic test_operators_and_words();
        send_string("_Az9\t==\rx!=7=!");
        send_byte(8'h80);
        send_byte(8'hFF);
        send_string(" '' \"s");
        send_byte(CH_NUL);
        send_string("=");
        send_byte(CH_NUL);
        settle();
    endtask

    // One long identifier streamed with no idle cycles on either side, then
    // a few more tokens and the terminator.
    task automatic test_long_token();
        tx_pace = 1'b0;
        rx_pace = 1'b0;
        send_byte(pick(word_set));
        repeat (LONG_IDENT - 1)
            send_byte($urandom_range(0, 3) == 0 ? pick(digit_set) : pick(word_set));
        send_string(" ;");
        send_byte(CH_NUL);
        settle();
    endtask

    // Random texts, each ended by a terminator, with pacing redrawn per text.
    task automatic test_random_texts();
        logic [7:0] text[$];
        int         sent;
        sent = 0;
        while (sent < TEXT_ITEMS)
        begin
            tx_pace = $urandom_range(0, 3) != 0;
            rx_pace = $urandom_range(0, 3) != 0;
            compose_text(text);
            foreach (text[i])
                send_byte(text[i]);
            sent += text.size();
        end
        settle();
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_byte  <= 8'h00;

        // Predictor starts where reset leaves the block.
        scan_state  = MODE_IDLE;
        tok_begin   = '0;
        next_offset = '0;
        tok_len     = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_punctuation();
        test_operators_and_words();
        test_random_texts();
        test_long_token();

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
